// ----- src/serial_packet_deframer_sum8_core_defines.svh -----
// Assertion macros for the serial packet deframer checker.
`ifndef SERIAL_PACKET_DEFRAMER_SUM8_CORE_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_SUM8_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPDS8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPDS8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/spds8_pkg.sv -----
// Types and constants shared by the serial packet deframer files.
package spds8_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [ByteW-1:0] StartCharReset     = 8'd36;
  localparam logic [ByteW-1:0] HeartbeatCharReset = 8'd33;

  localparam logic [CfgIdxW-1:0] CFG_START_CHAR     = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEARTBEAT_CHAR = 8'd1;

  typedef enum logic [1:0] {
    KIND_HEARTBEAT = 2'd0,
    KIND_HEADER    = 2'd1,
    KIND_PAYLOAD   = 2'd2,
    KIND_END       = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_LENGTH   = 6'b000010,
    PH_RESOURCE = 6'b000100,
    PH_ACTION   = 6'b001000,
    PH_PAYLOAD  = 6'b010000,
    PH_CHECK    = 6'b100000
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] resource_id;
    logic [ByteW-1:0] action_id;
    logic [ByteW-1:0] payload_length;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] payload_index;
    logic             last_payload;
    logic             checksum_ok;
  } res_t;

endpackage

// ----- src/spds8_if.sv -----
// Channel interfaces: received bytes, parse results and register writes.
interface spds8_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface spds8_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] resource_id;
  logic [7:0] action_id;
  logic [7:0] payload_length;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       last_payload;
  logic       checksum_ok;
  modport source (output valid, output kind, output resource_id, output action_id,
                  output payload_length, output payload_byte, output payload_index,
                  output last_payload, output checksum_ok, input ready);
  modport sink (input valid, input kind, input resource_id, input action_id,
                input payload_length, input payload_byte, input payload_index,
                input last_payload, input checksum_ok, output ready);
endinterface

interface spds8_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_index;
  logic [7:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- src/spds8_parser.sv -----
// Input byte register, frame phase machine, checksum and config registers.
module spds8_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  spds8_rx_if.sink          rx_i,
  spds8_cfg_if.sink         cfg_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output spds8_pkg::res_t   res_o
);
  import spds8_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             step;

  logic [ByteW-1:0] start_char_q, heartbeat_char_q;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] rsc_q, rsc_d;
  logic [ByteW-1:0] act_q, act_d;
  logic [ByteW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic             is_last;

  assign step       = in_valid_q && out_free_i;
  assign rx_i.ready = !in_valid_q || step;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q     <= StartCharReset;
      heartbeat_char_q <= HeartbeatCharReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        CFG_START_CHAR:     start_char_q     <= cfg_i.wdata;
        CFG_HEARTBEAT_CHAR: heartbeat_char_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign is_last = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    rsc_d       = rsc_q;
    act_d       = act_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.resource_id    = rsc_q;
    res_o.action_id      = act_q;
    res_o.payload_length = len_q;
    case (phase_q)
      PH_LENGTH: begin
        len_d   = in_byte_q;
        sum_d   = in_byte_q;
        phase_d = PH_RESOURCE;
      end
      PH_RESOURCE: begin
        rsc_d   = in_byte_q;
        sum_d   = sum_q + in_byte_q;
        phase_d = PH_ACTION;
      end
      PH_ACTION: begin
        act_d   = in_byte_q;
        sum_d   = sum_q + in_byte_q;
        pos_d   = '0;
        phase_d = (len_q == '0) ? PH_CHECK : PH_PAYLOAD;
        res_valid_o     = 1'b1;
        res_o.kind      = KIND_HEADER;
        res_o.action_id = in_byte_q;
      end
      PH_PAYLOAD: begin
        sum_d = sum_q + in_byte_q;
        res_valid_o         = 1'b1;
        res_o.kind          = KIND_PAYLOAD;
        res_o.payload_byte  = in_byte_q;
        res_o.payload_index = pos_q;
        res_o.last_payload  = is_last;
        if (is_last) begin
          phase_d = PH_CHECK;
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
      PH_CHECK: begin
        phase_d           = PH_IDLE;
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_END;
        res_o.checksum_ok = (in_byte_q == sum_q);
      end
      default: begin
        phase_d = PH_IDLE;
        if (in_byte_q == heartbeat_char_q) begin
          res_valid_o = 1'b1;
          res_o       = '0;
          res_o.kind  = KIND_HEARTBEAT;
        end else if (in_byte_q == start_char_q) begin
          phase_d = PH_LENGTH;
        end
      end
    endcase
    if (!step) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q   <= '0;
      rsc_q   <= '0;
      act_q   <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      rsc_q   <= rsc_d;
      act_q   <= act_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
    end
  end

endmodule

// ----- src/spds8_out_stage.sv -----
// Result register feeding the output channel.
module spds8_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_valid_i,
  input  spds8_pkg::res_t load_data_i,
  output logic            out_free_o,
  spds8_res_if.source     res_o
);
  import spds8_pkg::*;

  logic valid_q;
  res_t data_q;

  assign out_free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && load_valid_i) begin
      data_q <= load_data_i;
    end
  end

  assign res_o.valid          = valid_q;
  assign res_o.kind           = data_q.kind;
  assign res_o.resource_id    = data_q.resource_id;
  assign res_o.action_id      = data_q.action_id;
  assign res_o.payload_length = data_q.payload_length;
  assign res_o.payload_byte   = data_q.payload_byte;
  assign res_o.payload_index  = data_q.payload_index;
  assign res_o.last_payload   = data_q.last_payload;
  assign res_o.checksum_ok    = data_q.checksum_ok;

endmodule

// ----- src/serial_packet_deframer_sum8_core.sv -----
// Serial packet deframer with 8-bit additive checksum: top level.
//
// rx_i carries one received byte per transaction. res_o carries at most
// one result per byte: heartbeat, frame header (after the action id),
// one result per payload byte with index and last mark, and a frame end
// with the checksum verdict. cfg_i writes start_char (index 0) and
// heartbeat_char (index 1); it is always ready. The user must write it only
// while the block is idle; the block itself does not enforce this.
// A byte accepted into the input register is processed from there, and its
// result is loaded into the result register that drives res_o.
// Throughput: one byte per cycle while res_o is not stalled, set by the phase
// machine and 8-bit adder between the input and result registers.
// Reset: returns to idle, clears frame state and the valid flags of both
// registers, loads the default marker bytes ('$' start, '!' heartbeat).
// When res_o stalls, the held result stays put; at most one more byte is
// taken into the input register, then rx_i.ready drops until res_o drains.
module serial_packet_deframer_sum8_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  spds8_rx_if.sink     rx_i,
  spds8_cfg_if.sink    cfg_i,
  spds8_res_if.source  res_o
);
  import spds8_pkg::*;

  logic out_free;
  logic res_valid;
  res_t res;

  spds8_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .cfg_i       (cfg_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  spds8_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (res_valid),
    .load_data_i  (res),
    .out_free_o   (out_free),
    .res_o        (res_o)
  );

endmodule

// ----- src/spds8_checker.sv -----
// Port-level checks for the serial packet deframer, bound to the top level.
`include "serial_packet_deframer_sum8_core_defines.svh"

module spds8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] kind,
  input logic [7:0] resource_id,
  input logic [7:0] action_id,
  input logic [7:0] payload_length,
  input logic [7:0] payload_byte,
  input logic [7:0] payload_index,
  input logic       last_payload,
  input logic       checksum_ok
);
  import spds8_pkg::*;

  `SPDS8_ASSERT_NEXT(a_res_hold,
    res_valid && !res_ready,
    res_valid && $stable(kind) && $stable(payload_byte) && $stable(checksum_ok),
    "result changed while stalled")
  `SPDS8_ASSERT_NOW(a_hb_zero,
    res_valid && kind == KIND_HEARTBEAT,
    resource_id == 8'd0 && action_id == 8'd0 && payload_length == 8'd0 &&
      payload_byte == 8'd0 && payload_index == 8'd0 && !last_payload && !checksum_ok,
    "heartbeat fields not zero")
  `SPDS8_ASSERT_NOW(a_nonpay_zero,
    res_valid && kind != KIND_PAYLOAD,
    payload_byte == 8'd0 && payload_index == 8'd0 && !last_payload,
    "payload fields set outside payload result")
  `SPDS8_ASSERT_NOW(a_pay_index,
    res_valid && kind == KIND_PAYLOAD,
    payload_index < payload_length &&
      (last_payload == (payload_index == payload_length - 8'd1)) && !checksum_ok,
    "payload index or last mark inconsistent")

endmodule

bind serial_packet_deframer_sum8_core spds8_checker u_spds8_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid      (res_o.valid),
  .res_ready      (res_o.ready),
  .kind           (res_o.kind),
  .resource_id    (res_o.resource_id),
  .action_id      (res_o.action_id),
  .payload_length (res_o.payload_length),
  .payload_byte   (res_o.payload_byte),
  .payload_index  (res_o.payload_index),
  .last_payload   (res_o.last_payload),
  .checksum_ok    (res_o.checksum_ok)
);

// ----- sim/serial_packet_deframer_sum8_core_test.sv -----
// Self-checking testbench for the serial packet deframer with 8-bit additive checksum.
module serial_packet_deframer_sum8_core_test;
  import spds8_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned NumPhases     = 8;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic clk_i;
  logic rst_ni;

  spds8_rx_if  rx_if ();
  spds8_cfg_if cfg_if ();
  spds8_res_if res_if ();

  serial_packet_deframer_sum8_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // stimulus side
  logic [7:0]  bytes_todo[$];
  int unsigned bytes_pushed;
  int unsigned useful_bytes;
  idle_mode_e  idle_mode;
  int unsigned hold_left;
  logic [7:0]  gen_start;
  logic [7:0]  gen_heartbeat;

  // monitor side
  bit          rx_took;
  int unsigned bytes_taken;
  int unsigned cfg_count;
  int unsigned results_checked;
  int unsigned frames_closed;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  res_t        results_due[$];

  // deframer prediction state
  logic [7:0]  marker_start;
  logic [7:0]  marker_heartbeat;
  phase_e      frame_phase;
  logic [7:0]  frame_len;
  logic [7:0]  frame_res;
  logic [7:0]  frame_act;
  logic [7:0]  frame_pos;
  logic [7:0]  frame_sum;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic bit sit_out(input bit sender);
    case (idle_mode)
      IDLE_SEND: return sender && ($urandom_range(0, 99) < 73);
      IDLE_RECV: return !sender && ($urandom_range(0, 99) < 73);
      IDLE_BOTH: return $urandom_range(0, 99) < 9;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    res_t r;
    bit   emit;
    r    = '0;
    emit = 1'b0;
    case (frame_phase)
      PH_LENGTH: begin
        frame_len   = b;
        frame_sum   = b;
        frame_phase = PH_RESOURCE;
      end
      PH_RESOURCE: begin
        frame_res   = b;
        frame_sum   = frame_sum + b;
        frame_phase = PH_ACTION;
      end
      PH_ACTION: begin
        frame_act   = b;
        frame_sum   = frame_sum + b;
        frame_pos   = '0;
        frame_phase = (frame_len == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        r.kind      = KIND_HEADER;
        emit        = 1'b1;
      end
      PH_PAYLOAD: begin
        r.kind          = KIND_PAYLOAD;
        r.payload_byte  = b;
        r.payload_index = frame_pos;
        r.last_payload  = ({1'b0, frame_pos} + 9'd1) >= {1'b0, frame_len};
        frame_sum       = frame_sum + b;
        if (r.last_payload) frame_phase = PH_CHECK;
        else frame_pos = frame_pos + 8'd1;
        emit = 1'b1;
      end
      PH_CHECK: begin
        r.kind        = KIND_END;
        r.checksum_ok = (b == frame_sum);
        frame_phase   = PH_IDLE;
        emit          = 1'b1;
      end
      default: begin
        frame_phase = PH_IDLE;
        if (b == marker_heartbeat) begin
          r.kind = KIND_HEARTBEAT;
          emit   = 1'b1;
        end else if (b == marker_start) begin
          frame_phase = PH_LENGTH;
        end
      end
    endcase
    if (emit && r.kind != KIND_HEARTBEAT) begin
      r.resource_id    = frame_res;
      r.action_id      = frame_act;
      r.payload_length = frame_len;
    end
    if (emit) results_due.push_back(r);
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // byte driver
  always @(negedge clk_i) begin
    if (rst_ni && (!rx_if.valid || rx_took)) begin
      if (bytes_todo.size() != 0 && !sit_out(1'b1)) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= bytes_todo.pop_front();
      end else begin
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'($urandom_range(0, 255));
      end
    end
  end

  // result acceptance, with the long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left--;
    end else begin
      res_if.ready <= !sit_out(1'b0);
    end
  end

  // monitor, prediction and watchdog
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    bit   cfg_took;
    bit   res_took;
    if (rst_ni) begin
      rx_took  = rx_if.valid && rx_if.ready;
      cfg_took = cfg_if.valid && cfg_if.ready;
      res_took = res_if.valid && res_if.ready;
      if (rx_took) begin
        bytes_taken++;
        deframe_byte(rx_if.rx_byte);
      end
      if (cfg_took) begin
        if (cfg_if.reg_index == CFG_START_CHAR) marker_start = cfg_if.wdata;
        else if (cfg_if.reg_index == CFG_HEARTBEAT_CHAR) marker_heartbeat = cfg_if.wdata;
        cfg_count++;
      end
      if (res_took) begin
        got.kind           = kind_e'(res_if.kind);
        got.resource_id    = res_if.resource_id;
        got.action_id      = res_if.action_id;
        got.payload_length = res_if.payload_length;
        got.payload_byte   = res_if.payload_byte;
        got.payload_index  = res_if.payload_index;
        got.last_payload   = res_if.last_payload;
        got.checksum_ok    = res_if.checksum_ok;
        if (results_due.size() == 0) begin
          flag_mismatch("unexpected result kind", 8'(got.kind), 8'hxx);
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (want.kind == KIND_END) frames_closed++;
          if (got.kind !== want.kind) flag_mismatch("kind", 8'(got.kind), 8'(want.kind));
          if (got.resource_id !== want.resource_id)
            flag_mismatch("resource_id", got.resource_id, want.resource_id);
          if (got.action_id !== want.action_id)
            flag_mismatch("action_id", got.action_id, want.action_id);
          if (got.payload_length !== want.payload_length)
            flag_mismatch("payload_length", got.payload_length, want.payload_length);
          if (got.payload_byte !== want.payload_byte)
            flag_mismatch("payload_byte", got.payload_byte, want.payload_byte);
          if (got.payload_index !== want.payload_index)
            flag_mismatch("payload_index", got.payload_index, want.payload_index);
          if (got.last_payload !== want.last_payload)
            flag_mismatch("last_payload", 8'(got.last_payload), 8'(want.last_payload));
          if (got.checksum_ok !== want.checksum_ok)
            flag_mismatch("checksum_ok", 8'(got.checksum_ok), 8'(want.checksum_ok));
        end
      end
      if (rx_took || cfg_took || res_took) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit counts);
    bytes_todo.push_back(b);
    bytes_pushed++;
    if (counts) useful_bytes++;
  endtask

  // body is length, resource, action, payload; cut_at > 0 truncates the frame
  task automatic push_frame(input logic [7:0] body[$], input bit good_sum,
                            input int unsigned cut_at);
    logic [7:0]  framed[$];
    logic [7:0]  sum;
    int unsigned n;
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    framed = body;
    framed.push_front(gen_start);
    framed.push_back(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    n = (cut_at != 0 && cut_at < framed.size()) ? cut_at : framed.size();
    for (int unsigned i = 0; i < n; i++) push_byte(framed[i], 1'b1);
  endtask

  task automatic push_random_frame(input int unsigned len);
    logic [7:0] body[$];
    body = {8'(len), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    repeat (len) body.push_back(8'($urandom_range(0, 255)));
    push_frame(body, $urandom_range(0, 99) < 80,
               ($urandom_range(0, 99) < 5) ? $urandom_range(1, len + 4) : 0);
  endtask

  task automatic fill_random(input int unsigned target);
    int unsigned base;
    int unsigned pick;
    base = useful_bytes;
    while (useful_bytes - base < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        push_random_frame(($urandom_range(0, 49) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 7));
      else if (pick < 85) push_byte(gen_heartbeat, 1'b1);
      else push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic drain;
    while (bytes_taken != bytes_pushed || results_due.size() != 0) @(negedge clk_i);
    // a frame byte with no result may still sit in the input register
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    int unsigned seen;
    seen = cfg_count;
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= val;
    do @(negedge clk_i); while (cfg_count == seen);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_markers(input logic [7:0] start_val, input logic [7:0] heartbeat_val);
    write_reg(CFG_START_CHAR, start_val);
    write_reg(CFG_HEARTBEAT_CHAR, heartbeat_val);
    gen_start     = start_val;
    gen_heartbeat = heartbeat_val;
  endtask

  initial begin
    logic [7:0] start_set[NumPhases];
    logic [7:0] heartbeat_set[NumPhases];
    start_set     = '{8'h24, 8'h00, 8'hFF, 8'h7E, 8'h00, 8'hFF, 8'h21, 8'h80};
    heartbeat_set = '{8'h21, 8'hFF, 8'h00, 8'h7E, 8'h00, 8'hFF, 8'h24, 8'h01};

    rst_ni           = 1'b0;
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wdata     = '0;
    res_if.ready     = 1'b0;
    idle_mode        = IDLE_NONE;
    hold_left        = 0;
    gen_start        = StartCharReset;
    gen_heartbeat    = HeartbeatCharReset;
    marker_start     = StartCharReset;
    marker_heartbeat = HeartbeatCharReset;
    frame_phase      = PH_IDLE;
    frame_len        = '0;
    frame_res        = '0;
    frame_act        = '0;
    frame_pos        = '0;
    frame_sum        = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset markers, dropped bytes, empty payload, markers inside a frame,
    // bad checksum, extreme field values
    push_byte(HeartbeatCharReset, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_frame({8'h00, 8'hFF, 8'h00}, 1'b1, 0);
    push_frame({8'h02, StartCharReset, HeartbeatCharReset, HeartbeatCharReset,
                StartCharReset}, 1'b1, 0);
    push_frame({8'h01, 8'h00, 8'hFF, 8'hFF}, 1'b0, 0);
    drain();
    // start and heartbeat equal: heartbeat wins
    set_markers(8'h55, 8'h55);
    push_byte(8'h55, 1'b1);
    push_byte(8'h24, 1'b0);
    drain();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p == 4) set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else set_markers(start_set[p], heartbeat_set[p]);
      idle_mode = idle_mode_e'(p % 4);
      if (p == 4) push_random_frame(255);
      fill_random(ItemsPerPhase);
      // receiver holds off while the sender keeps going
      if (p == 0) hold_left = 60;
      drain();
    end

    repeat (8) @(negedge clk_i);
    if (results_due.size() != 0)
      flag_mismatch("results never delivered", 8'(results_due.size()), 8'h00);
    $display("Covered %0d bytes over %0d marker settings and four idling modes;",
             bytes_taken, NumPhases + 2);
    $display("%0d results checked, %0d frames closed, %0d register writes.",
             results_checked, frames_closed, cfg_count);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- serial_packet_deframer_sum8_core.f -----
+incdir+src
src/spds8_pkg.sv
src/spds8_if.sv
src/spds8_parser.sv
src/spds8_out_stage.sv
src/serial_packet_deframer_sum8_core.sv
src/spds8_checker.sv
sim/serial_packet_deframer_sum8_core_test.sv
